FILE: rtl/podc_pkg.sv
package podc_pkg;

	// Field widths fixed by the interface
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int OUT_W  = 22;
	// A day ordinal of any 14-bit year fits in 23 bits
	localparam int ORD_W  = 23;
	localparam int NUM_DATES = 4;

	localparam logic [MON_W-1:0] MON_FEB  = MON_W'(2);
	localparam logic [MON_W-1:0] MON_LAST = MON_W'(12);
	localparam logic [6:0] CENTURY = 7'd100;
	// floor(y * 5243 / 2^19) equals y / 100 for every 14-bit year
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [DAY_W-1:0] FEB_LEAP_LEN = DAY_W'(29);
	localparam logic [DAY_W-1:0] FEB_LEN      = DAY_W'(28);
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	typedef logic [DAY_W-1:0]  day_t;
	typedef logic [MON_W-1:0]  mon_t;
	typedef logic [YEAR_W-1:0] year_t;
	typedef logic [ORD_W-1:0]  ord_t;

	// Ordinal unit sequencer
	typedef enum logic [2:0] {
		ORD_IDLE,
		ORD_DIV,
		ORD_MUL,
		ORD_SUM1,
		ORD_SUM2
	} ord_state_t;

	// Top level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DATE,
		ST_WAIT,
		ST_CMP,
		ST_DIFF
	} top_state_t;

	// Status from the ordinal unit to the sequencer
	typedef struct packed {
		logic done;
		logic bad;
	} ord_sts_t;

	// Days in a month for a common year; February handled by the caller
	function automatic day_t month_len(input mon_t m);
		day_t len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
			4'd2:                                       len = FEB_LEN;
			default:                                    len = DAY_W'(0);
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m (common year)
	function automatic logic [8:0] days_before(input mon_t m);
		logic [8:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/podc_ord_unit.sv
// Converts one date to a day ordinal (0001-01-01 is day 1) and checks it.
// The year is split by 100 with a reciprocal multiply, then one multiply
// and two accumulate steps finish the count.
module podc_ord_unit import podc_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  day_t     day,
	input  mon_t     month,
	input  year_t    year,
	output ord_t     ord,
	output ord_sts_t sts
);

	ord_state_t       st_q, st_d;
	logic [7:0]       quo_q;
	ord_t             prod_q;
	ord_t             acc_q;
	logic [7:0]       p100_q;
	logic             leap_q;
	logic             bad_q;
	logic             done_q;

	year_t              p;
	logic [RECIP_W-1:0] recip;
	year_t              hundreds;
	logic [7:0]         qy;
	logic               ry_zero;
	logic               leap;
	day_t               mlen;
	logic               yr_bad;
	logic               mon_bad;
	logic               day_bad;

	assign p = year - YEAR_W'(1);

	// Divide by 100 through a reciprocal multiply
	assign recip = {{(RECIP_W - YEAR_W){1'b0}}, year} * RECIP_W'(RECIP_100);

	// Leap year and range checks once the quotient is in
	assign qy       = quo_q;
	assign hundreds = {6'd0, quo_q} * {7'd0, CENTURY};
	assign ry_zero  = year == hundreds;
	assign leap    = (year[1:0] == 2'd0) && (!ry_zero || qy[1:0] == 2'd0);
	assign mlen    = (month == MON_FEB) ? (leap ? FEB_LEAP_LEN : FEB_LEN) : month_len(month);
	assign yr_bad  = (year == '0) || (int'({18'd0, year}) > MAX_YEAR);
	assign mon_bad = (month == '0) || (month > MON_LAST);
	assign day_bad = (day == '0) || (day > mlen);

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ORD_IDLE: if (start) st_d = ORD_DIV;
			ORD_DIV:  st_d = ORD_MUL;
			ORD_MUL:  st_d = ORD_SUM1;
			ORD_SUM1: st_d = ORD_SUM2;
			ORD_SUM2: st_d = ORD_IDLE;
			default:  st_d = ORD_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ORD_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == ORD_SUM2);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ORD_DIV: begin
				quo_q <= recip[RECIP_W-1:RECIP_SHIFT];
			end
			ORD_MUL: begin
				prod_q <= ORD_W'({9'd0, p} * {5'd0, DAYS_PER_YEAR});
				p100_q <= ry_zero ? qy - 8'd1 : qy;
				leap_q <= leap;
				bad_q  <= yr_bad || mon_bad || day_bad;
			end
			ORD_SUM1: begin
				acc_q <= prod_q + ORD_W'(p >> 2) + ORD_W'(day);
			end
			ORD_SUM2: begin
				acc_q <= acc_q - ORD_W'(p100_q) + ORD_W'(p100_q >> 2)
					+ ORD_W'(days_before(month))
					+ ORD_W'(leap_q && (month > MON_FEB));
			end
			default: ;
		endcase
	end

	assign ord      = acc_q;
	assign sts.done = done_q;
	assign sts.bad  = bad_q;

endmodule

FILE: rtl/period_overlap_day_counter_unit.sv
// Overlap day counter: takes two periods (start and end Gregorian dates) and
// returns the day distance between the later start and the earlier end, or 0
// when the periods are disjoint; any impossible date sets invalid_date and
// gives 0. One request at a time: in_stall drops in the same cycle that the
// result is presented, and the next request is taken only after that. The
// time is set by the shared date-to-ordinal unit, which runs once per date
// (four times), plus the ST_CMP state to compare and the ST_DIFF state to
// load the result. A finished result sits in the output register, so the
// next request is taken while it waits; a request that finishes while an
// earlier result is still stalled holds until the output frees.
module period_overlap_day_counter_unit import podc_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  day_t             first_start_day,
	input  mon_t             first_start_month,
	input  year_t            first_start_year,
	input  day_t             first_end_day,
	input  mon_t             first_end_month,
	input  year_t            first_end_year,
	input  day_t             second_start_day,
	input  mon_t             second_start_month,
	input  year_t            second_start_year,
	input  day_t             second_end_day,
	input  mon_t             second_end_month,
	input  year_t            second_end_year,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] overlap_days,
	output logic             invalid_date
);

	top_state_t st_q, st_d;
	logic [1:0] idx_q;
	logic       bad_q;
	day_t       day_q [NUM_DATES];
	mon_t       mon_q [NUM_DATES];
	year_t      year_q [NUM_DATES];
	ord_t       ord_q [NUM_DATES];
	logic       disj_q;
	ord_t       lo_q;
	ord_t       hi_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] days_q;
	logic             inv_q;

	logic     accept;
	logic     start;
	logic     out_free;
	logic     load_out;
	ord_t     ord;
	ord_sts_t ord_sts;
	ord_t     diff;

	assign accept   = in_valid && !in_stall;
	assign in_stall = st_q != ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// Shared date-to-ordinal unit
	podc_ord_unit #(
		.MAX_YEAR (MAX_YEAR)
	) u_ord (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.day    (day_q[idx_q]),
		.month  (mon_q[idx_q]),
		.year   (year_q[idx_q]),
		.ord    (ord),
		.sts    (ord_sts)
	);

	// Sequencer: next state and strobes
	always_comb begin
		st_d     = st_q;
		start    = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = ST_DATE;
			ST_DATE: begin
				start = 1'b1;
				st_d  = ST_WAIT;
			end
			ST_WAIT: begin
				if (ord_sts.done)
					st_d = (idx_q == 2'(NUM_DATES - 1)) ? ST_CMP : ST_DATE;
			end
			ST_CMP: st_d = ST_DIFF;
			ST_DIFF: begin
				if (out_free) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				idx_q <= '0;
				bad_q <= 1'b0;
			end else if (st_q == ST_WAIT && ord_sts.done) begin
				idx_q <= idx_q + 2'd1;
				bad_q <= bad_q || ord_sts.bad;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Absolute distance between later start and earlier end
	assign diff = (lo_q > hi_q) ? lo_q - hi_q : hi_q - lo_q;

	// Request capture, ordinal store, compare and result
	always_ff @(posedge clk) begin
		if (accept) begin
			day_q[0] <= first_start_day;
			mon_q[0] <= first_start_month;
			year_q[0] <= first_start_year;
			day_q[1] <= first_end_day;
			mon_q[1] <= first_end_month;
			year_q[1] <= first_end_year;
			day_q[2] <= second_start_day;
			mon_q[2] <= second_start_month;
			year_q[2] <= second_start_year;
			day_q[3] <= second_end_day;
			mon_q[3] <= second_end_month;
			year_q[3] <= second_end_year;
		end
		if (st_q == ST_WAIT && ord_sts.done)
			ord_q[idx_q] <= ord;
		if (st_q == ST_CMP) begin
			disj_q <= (ord_q[0] > ord_q[3]) || (ord_q[1] < ord_q[2]);
			lo_q   <= (ord_q[0] > ord_q[2]) ? ord_q[0] : ord_q[2];
			hi_q   <= (ord_q[1] < ord_q[3]) ? ord_q[1] : ord_q[3];
		end
		if (load_out) begin
			inv_q <= bad_q;
			if (bad_q || disj_q)
				days_q <= '0;
			else if (diff > ORD_W'(OUT_MAX))
				days_q <= OUT_MAX;
			else
				days_q <= diff[OUT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign overlap_days = days_q;
	assign invalid_date = inv_q;

	// An invalid date always reports zero days
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_date |-> overlap_days == '0)
		else $error("invalid date with nonzero day count");

	// A request holds off the input until its result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after request accepted");

	// Ordinal unit reports completion only while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		ord_sts.done |-> st_q == ST_WAIT)
		else $error("ordinal done outside wait state");

	// Loading a result never overwrites one still stalled at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

endmodule
